// ===== hdl/hscb_pkg.sv =====
// shared constants, types and helpers of the harq soft-combining buffer
package hscb_pkg;

  localparam int BUFFER_DEPTH  = 2048;
  localparam int ADDR_W        = $clog2(BUFFER_DEPTH);
  localparam int IN_WIDTH      = 8;
  localparam int ACC_WIDTH     = 12;
  localparam int MAX_STREAMS   = 8;
  localparam int MIN_STREAMS   = 2;
  localparam int STREAM_W      = 4;
  localparam int ATTEMPT_W     = 3;
  localparam int LEN_W         = 12;
  localparam int COUNT_W       = 12;
  localparam int COUNT_MAX     = (1 << COUNT_W) - 1;
  localparam int OP_W          = 2;
  localparam int STATUS_W      = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 12;
  localparam int RESET_STREAMS = 6;
  localparam int RESET_LENGTH  = 1680;
  localparam int EPOCH_W       = 6;
  localparam int EPOCH_MAX     = (1 << EPOCH_W) - 1;
  localparam int RAM_W         = EPOCH_W + ACC_WIDTH;
  localparam int Q_DEPTH       = 2;
  localparam int Q_PTR_W       = $clog2(Q_DEPTH);

  localparam logic [OP_W-1:0] OP_NEW_BLOCK   = 2'd0;
  localparam logic [OP_W-1:0] OP_NEW_ATTEMPT = 2'd1;
  localparam logic [OP_W-1:0] OP_ACCUMULATE  = 2'd2;
  localparam logic [OP_W-1:0] OP_READ        = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PAST = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 2'd0,
    REG_STREAMS = 2'd1,
    REG_ATTEMPT = 2'd2,
    REG_LENGTH  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_CLEAR = 3'd1,
    CMD_ACC   = 3'd2,
    CMD_READ  = 3'd3,
    CMD_DROP  = 3'd4,
    CMD_PAST  = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                    kind;
    logic [ADDR_W-1:0]            addr;
    logic signed [IN_WIDTH-1:0]   llr;
  } cmd_t;

  function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W:0] s);
    return (s > (COUNT_W+1)'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : s[COUNT_W-1:0];
  endfunction

endpackage

// ===== hdl/hscb_ifs.sv =====
// valid/ready channel interfaces of the harq soft-combining buffer
interface hscb_in_if import hscb_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [OP_W-1:0]             opcode;
  logic signed [IN_WIDTH-1:0]  llr_in;
  logic [ADDR_W-1:0]           read_index;

  modport source (output valid, opcode, llr_in, read_index, input ready);
  modport sink   (input valid, opcode, llr_in, read_index, output ready);
endinterface

interface hscb_out_if import hscb_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [ACC_WIDTH-1:0]  combined_value;
  logic [ADDR_W-1:0]            position;
  logic [STATUS_W-1:0]          status;

  modport source (output valid, combined_value, position, status, input ready);
  modport sink   (input valid, combined_value, position, status, output ready);
endinterface

interface hscb_cfg_if import hscb_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/hscb_ram.sv =====
// generic single-write, single-read ram with registered read data
module hscb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/hscb_front.sv =====
// front end: configuration registers, position counters and item classification
module hscb_front import hscb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  hscb_in_if.sink     in_ch,
  hscb_cfg_if.sink    cfg_ch,
  input  logic        q_full,
  input  logic        clearing,
  output logic        push,
  output cmd_t        push_cmd
);

  logic                  mode_r;
  logic [STREAM_W-1:0]   streams_r;
  logic [ATTEMPT_W-1:0]  attempt_r;
  logic [LEN_W-1:0]      length_r;
  logic [COUNT_W-1:0]    item_r, item_nxt;
  logic [COUNT_W-1:0]    row_r, row_nxt;

  logic [STREAM_W-1:0]   m_eff;
  logic [STREAM_W-1:0]   stream;
  logic [LEN_W-1:0]      eff_len;
  logic [COUNT_W-1:0]    row_step;
  logic [COUNT_W:0]      pos;
  logic                  no_stream;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full && !clearing;
  assign push         = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b1;
      streams_r <= STREAM_W'(RESET_STREAMS);
      attempt_r <= '0;
      length_r  <= LEN_W'(RESET_LENGTH);
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_MODE:    mode_r    <= cfg_ch.data[0];
        REG_STREAMS: streams_r <= cfg_ch.data[STREAM_W-1:0];
        REG_ATTEMPT: attempt_r <= cfg_ch.data[ATTEMPT_W-1:0];
        REG_LENGTH:  length_r  <= cfg_ch.data[LEN_W-1:0];
        default:     mode_r    <= mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r <= '0;
      row_r  <= '0;
    end else if (push) begin
      item_r <= item_nxt;
      row_r  <= row_nxt;
    end
  end

  always_comb begin
    if (streams_r < STREAM_W'(MIN_STREAMS)) begin
      m_eff = STREAM_W'(MIN_STREAMS);
    end else if (streams_r > STREAM_W'(MAX_STREAMS)) begin
      m_eff = STREAM_W'(MAX_STREAMS);
    end else begin
      m_eff = streams_r;
    end
  end

  assign eff_len  = (length_r > LEN_W'(BUFFER_DEPTH)) ? LEN_W'(BUFFER_DEPTH) : length_r;
  assign stream   = STREAM_W'(attempt_r) + STREAM_W'(1);
  assign row_step = sat_count({1'b0, row_r} + (COUNT_W+1)'(m_eff));

  always_comb begin
    item_nxt      = item_r;
    row_nxt       = row_r;
    pos           = '0;
    no_stream     = 1'b0;
    push_cmd.kind = CMD_NONE;
    push_cmd.addr = '0;
    push_cmd.llr  = in_ch.llr_in;
    unique case (in_ch.opcode)
      OP_NEW_BLOCK: begin
        item_nxt      = '0;
        row_nxt       = '0;
        push_cmd.kind = CMD_CLEAR;
      end
      OP_NEW_ATTEMPT: begin
        item_nxt = '0;
        row_nxt  = '0;
      end
      OP_ACCUMULATE: begin
        if (!mode_r) begin
          pos      = {1'b0, item_r};
          item_nxt = sat_count({1'b0, item_r} + (COUNT_W+1)'(1));
        end else if (attempt_r == '0) begin
          // first item of a row is stream 0, second is stream 1
          pos = {1'b0, row_r} + (COUNT_W+1)'(item_r[0]);
          if (item_r[0]) begin
            item_nxt = '0;
            row_nxt  = row_step;
          end else begin
            item_nxt = COUNT_W'(1);
          end
        end else if (stream >= m_eff) begin
          no_stream = 1'b1;
        end else begin
          pos     = {1'b0, row_r} + (COUNT_W+1)'(stream);
          row_nxt = row_step;
        end
        push_cmd.kind = (no_stream || pos >= (COUNT_W+1)'(eff_len)) ? CMD_DROP : CMD_ACC;
        push_cmd.addr = pos[ADDR_W-1:0];
      end
      OP_READ: begin
        push_cmd.addr = in_ch.read_index;
        push_cmd.kind = (LEN_W'(in_ch.read_index) >= eff_len) ? CMD_PAST : CMD_READ;
      end
      default: push_cmd.kind = CMD_NONE;
    endcase
  end

endmodule

// ===== hdl/hscb_queue.sv =====
// short command queue between the front end and the back end
module hscb_queue import hscb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  cmd_t  push_cmd,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output cmd_t  pop_cmd
);

  cmd_t                 slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_PTR_W:0]     count_r;

  assign full    = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign valid   = (count_r != '0);
  assign pop_cmd = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (Q_PTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (Q_PTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== hdl/hscb_back.sv =====
// back end: buffer ram, epoch-tagged read-modify-write and result register
module hscb_back import hscb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  hscb_out_if.source  out_ch,
  output logic        clearing
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } back_state_t;

  back_state_t                  state_r, state_nxt;
  logic [ADDR_W-1:0]            clr_cnt_r, clr_cnt_nxt;
  logic [EPOCH_W-1:0]           epoch_r, epoch_nxt;
  cmd_t                         hold_r, hold_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic signed [ACC_WIDTH-1:0]  out_val_r, out_val_nxt;
  logic [ADDR_W-1:0]            out_pos_r, out_pos_nxt;
  logic [STATUS_W-1:0]          out_st_r, out_st_nxt;

  logic                         we, re;
  logic [ADDR_W-1:0]            waddr, raddr;
  logic [RAM_W-1:0]             wdata, rdata;

  logic                         out_free;
  logic signed [ACC_WIDTH-1:0]  old_val;
  logic signed [ACC_WIDTH:0]    sum_wide;
  logic signed [ACC_WIDTH-1:0]  sum_sat;

  hscb_ram #(
    .WIDTH (RAM_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign clearing              = (state_r == S_CLEAR);
  assign out_free              = !out_valid_r || out_ch.ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.combined_value = out_val_r;
  assign out_ch.position       = out_pos_r;
  assign out_ch.status         = out_st_r;

  // an entry counts as written only if its tag matches the current block
  assign old_val  = (rdata[RAM_W-1 -: EPOCH_W] == epoch_r) ? rdata[ACC_WIDTH-1:0] : '0;
  assign sum_wide = {old_val[ACC_WIDTH-1], old_val}
                  + {{(ACC_WIDTH+1-IN_WIDTH){hold_r.llr[IN_WIDTH-1]}}, hold_r.llr};
  assign sum_sat  = (sum_wide[ACC_WIDTH] != sum_wide[ACC_WIDTH-1])
                  ? {sum_wide[ACC_WIDTH], {(ACC_WIDTH-1){!sum_wide[ACC_WIDTH]}}}
                  : sum_wide[ACC_WIDTH-1:0];

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    epoch_nxt     = epoch_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_val_nxt   = out_val_r;
    out_pos_nxt   = out_pos_r;
    out_st_nxt    = out_st_r;
    q_pop         = 1'b0;
    re            = 1'b0;
    raddr         = q_cmd.addr;
    we            = 1'b0;
    waddr         = hold_r.addr;
    wdata         = {epoch_r, sum_sat};
    unique case (state_r)
      S_CLEAR: begin
        // tag zero is never a live epoch
        we          = 1'b1;
        waddr       = clr_cnt_r;
        wdata       = '0;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(BUFFER_DEPTH - 1)) begin
          epoch_nxt = EPOCH_W'(1);
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_cmd.kind) inside
            CMD_ACC, CMD_READ: begin
              re        = 1'b1;
              hold_nxt  = q_cmd;
              state_nxt = S_LOOK;
            end
            CMD_CLEAR: begin
              out_valid_nxt = 1'b1;
              out_val_nxt   = '0;
              out_pos_nxt   = '0;
              out_st_nxt    = ST_OK;
              if (epoch_r == EPOCH_W'(EPOCH_MAX)) begin
                clr_cnt_nxt = '0;
                state_nxt   = S_CLEAR;
              end else begin
                epoch_nxt = epoch_r + EPOCH_W'(1);
              end
            end
            CMD_DROP: begin
              out_valid_nxt = 1'b1;
              out_val_nxt   = '0;
              out_pos_nxt   = '0;
              out_st_nxt    = ST_DROP;
            end
            CMD_PAST: begin
              out_valid_nxt = 1'b1;
              out_val_nxt   = '0;
              out_pos_nxt   = q_cmd.addr;
              out_st_nxt    = ST_PAST;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_val_nxt   = '0;
              out_pos_nxt   = '0;
              out_st_nxt    = ST_OK;
            end
          endcase
        end
      end
      S_LOOK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = hold_r.addr;
          out_st_nxt    = ST_OK;
          if (hold_r.kind == CMD_ACC) begin
            we          = 1'b1;
            out_val_nxt = sum_sat;
          end else begin
            out_val_nxt = old_val;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      epoch_r     <= EPOCH_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      epoch_r     <= epoch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r    <= hold_nxt;
    out_val_r <= out_val_nxt;
    out_pos_r <= out_pos_nxt;
    out_st_r  <= out_st_nxt;
  end

endmodule

// ===== hdl/harq_soft_combining_buffer.sv =====
// top level of the harq soft-combining buffer
//
//   channel | direction | carries
//   --------+-----------+---------------------------------------------
//   in_ch   | in        | opcode, llr_in, read_index
//   out_ch  | out       | combined_value, position, status
//   cfg_ch  | in        | index, data (mode, streams, attempt, length)
//
// new block, new attempt, dropped items and reads past the length are answered from
// the idle state of the back end; accumulate and an in-range read also pass through
// the look state, for the registered read of the buffer ram ahead of its write-back.
// after reset, and after every 63rd new block when the epoch tag wraps, a
// clearing pass sweeps all 2048 ram entries; in_ch.ready is low meanwhile.
// a 2-deep queue and the result register let input and output stall apart.
module harq_soft_combining_buffer import hscb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  hscb_in_if.sink     in_ch,
  hscb_out_if.source  out_ch,
  hscb_cfg_if.sink    cfg_ch
);

  logic  push, q_full, q_valid, q_pop, clearing;
  cmd_t  push_cmd, q_cmd;

  hscb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_full   (q_full),
    .clearing (clearing),
    .push     (push),
    .push_cmd (push_cmd)
  );

  hscb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (q_cmd)
  );

  hscb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .out_ch   (out_ch),
    .clearing (clearing)
  );

  // no transfer is taken in while the ram sweep runs
  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n)
    clearing |-> !(in_ch.valid && in_ch.ready)
  ) else $error("input transfer during clearing pass");

  // the back end only pops a queue that holds something
  a_pop_nonempty: assert property (
    @(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid
  ) else $error("pop from empty queue");

  a_drop_fields_zero: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_DROP) |->
      (out_ch.combined_value == '0 && out_ch.position == '0)
  ) else $error("dropped accumulate with nonzero fields");

  a_past_value_zero: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_PAST) |-> (out_ch.combined_value == '0)
  ) else $error("read past length with nonzero value");

endmodule
